FILE: rtl/pqda_pkg.sv
// shared types and constants for the pq distance accumulator
// command codes, field widths, default sizes and the saturating add
// no dependencies
package pqda_pkg;

	// default sizes
	localparam int DEF_NUM_CODEBOOKS = 64;
	localparam int DEF_NUM_LANES     = 32;
	localparam int DEF_NUM_CODES     = 256;

	// field widths
	localparam int CMD_W   = 2;
	localparam int CB_W    = 6;
	localparam int CODE_W  = 8;
	localparam int LANE_W  = 5;
	localparam int VAL_W   = 16;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	localparam logic [VAL_W-1:0] SAT_MAX = '1;

	// command carried in tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_DIST = 2'd0,
		CMD_LOAD_MAG  = 2'd1,
		CMD_ACCUM     = 2'd2,
		CMD_EMIT      = 2'd3
	} cmd_t;

	// unsigned add that sticks at the top value
	function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[VAL_W] ? SAT_MAX : s[VAL_W-1:0];
	endfunction

endpackage

FILE: rtl/pqda_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module pqda_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/pq_quantized_distance_accumulator.sv
// top level of the product quantization distance scan accumulator
// uses pqda_pkg and two pqda_ram instances for the distance and magnitude tables
//
//  channel   | direction | fields
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | tuser: command; tdata: codebook, code, lane, value
//  m_axis    | out       | tdata: out_lane, distance_sum, magnitude_sum; tlast: last
//  cfg       | in        | magnitude_enable write
//
// load and accumulate take one item every cycle while no emit run is under way; the
// table ram read is registered and the lane add happens in the following stage.
// emit returns one lane per cycle while the output is not stalled, NUM_LANES
// results; the accumulator read port is shared, so no input is taken from the
// emit transfer until the last lane is in the output register.
// reset clears accumulators and control; the tables are undefined until loaded.
// an output stall holds the output register and pauses the emit run.
module pq_quantized_distance_accumulator
	import pqda_pkg::*;
#(
	parameter int NUM_CODEBOOKS = DEF_NUM_CODEBOOKS,
	parameter int NUM_LANES     = DEF_NUM_LANES,
	parameter int NUM_CODES     = DEF_NUM_CODES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // codebook, code, lane, value, zero pad
	input  logic [CMD_W-1:0]       s_axis_tuser,  // command
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_lane, distance_sum, magnitude_sum, pad
	output logic                   m_axis_tlast,  // last
	input  logic                   cfg_wen,
	input  logic                   cfg_wdata      // magnitude_enable
);

	localparam int DEPTH = NUM_CODEBOOKS * NUM_CODES;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int LIW   = NUM_LANES > 1 ? $clog2(NUM_LANES) : 1;
	localparam logic [LIW-1:0] LAST_LANE = LIW'(NUM_LANES - 1);

	// input field unpacking
	cmd_t              cmd_in;
	logic [CB_W-1:0]   codebook_in;
	logic [CODE_W-1:0] code_in;
	logic [LANE_W-1:0] lane_in;
	logic [VAL_W-1:0]  value_in;
	logic              s_xfer;

	assign cmd_in      = cmd_t'(s_axis_tuser);
	assign codebook_in = s_axis_tdata[5:0];
	assign code_in     = s_axis_tdata[13:6];
	assign lane_in     = s_axis_tdata[18:14];
	assign value_in    = s_axis_tdata[34:19];
	assign s_xfer      = s_axis_tvalid && s_axis_tready;

	// table address and range checks
	logic [31:0]    addr_ext;
	logic [31:0]    lane_ext;
	logic [AW-1:0]  taddr;
	logic           index_ok;
	logic           lane_ok;

	assign addr_ext = 32'(codebook_in) * 32'(NUM_CODES) + 32'(code_in);
	assign taddr    = addr_ext[AW-1:0];
	assign index_ok = (32'(codebook_in) < 32'(NUM_CODEBOOKS)) &&
	                  (32'(code_in) < 32'(NUM_CODES));
	assign lane_ext = 32'(lane_in);
	assign lane_ok  = lane_ext < 32'(NUM_LANES);

	// configuration register
	logic mag_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_en_q <= 1'b0;
		end else if (cfg_wen) begin
			mag_en_q <= cfg_wdata;
		end
	end

	// table memories
	logic [VAL_W-1:0] dist_rd;
	logic [VAL_W-1:0] mag_rd;

	pqda_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_dist_ram (
		.clk   (clk),
		.we    (s_xfer && cmd_in == CMD_LOAD_DIST && index_ok),
		.waddr (taddr),
		.wdata (value_in),
		.raddr (taddr),
		.rdata (dist_rd)
	);

	pqda_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_mag_ram (
		.clk   (clk),
		.we    (s_xfer && cmd_in == CMD_LOAD_MAG && index_ok),
		.waddr (taddr),
		.wdata (value_in),
		.raddr (taddr),
		.rdata (mag_rd)
	);

	// stage 1 registers, aligned with the ram read data
	logic           acc_s1;
	logic           emit_s1;
	logic           hit_s1;
	logic [LIW-1:0] lane_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1  <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			acc_s1  <= s_xfer && cmd_in == CMD_ACCUM && lane_ok;
			emit_s1 <= s_xfer && cmd_in == CMD_EMIT;
		end
	end

	always_ff @(posedge clk) begin
		hit_s1  <= index_ok;
		lane_s1 <= lane_ext[LIW-1:0];
	end

	// emit sequencer
	logic           busy_q;
	logic [LIW-1:0] emit_lane_q;
	logic           emit_take;

	assign emit_take = busy_q && (!m_axis_tvalid || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			emit_lane_q <= '0;
		end else if (emit_s1) begin
			busy_q      <= 1'b1;
			emit_lane_q <= '0;
		end else if (emit_take) begin
			if (emit_lane_q == LAST_LANE) begin
				busy_q <= 1'b0;
			end
			emit_lane_q <= emit_lane_q + 1'b1;
		end
	end

	assign s_axis_tready = !busy_q && !emit_s1;

	// lane accumulators with one shared read and write address
	logic [VAL_W-1:0] dacc_q [NUM_LANES];
	logic [VAL_W-1:0] macc_q [NUM_LANES];
	logic [LIW-1:0]   acc_addr;
	logic [VAL_W-1:0] dacc_rd;
	logic [VAL_W-1:0] macc_rd;
	logic [VAL_W-1:0] dacc_nxt;
	logic [VAL_W-1:0] macc_nxt;
	logic             acc_we;

	assign acc_addr = busy_q ? emit_lane_q : lane_s1;
	assign dacc_rd  = dacc_q[acc_addr];
	assign macc_rd  = macc_q[acc_addr];
	assign acc_we   = acc_s1 || emit_take;

	// saturating update, or clear as the lane leaves on emit
	always_comb begin
		dacc_nxt = '0;
		macc_nxt = '0;
		if (acc_s1) begin
			dacc_nxt = sat_add(dacc_rd, hit_s1 ? dist_rd : '0);
			macc_nxt = (mag_en_q && hit_s1) ? sat_add(macc_rd, mag_rd) : macc_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				dacc_q[i] <= '0;
				macc_q[i] <= '0;
			end
		end else if (acc_we) begin
			dacc_q[acc_addr] <= dacc_nxt;
			macc_q[acc_addr] <= macc_nxt;
		end
	end

	// output register
	logic [31:0]       emit_lane_ext;
	logic [LANE_W-1:0] out_lane_q;
	logic [VAL_W-1:0]  dist_sum_q;
	logic [VAL_W-1:0]  mag_sum_q;
	logic              last_q;
	logic              out_valid_q;

	assign emit_lane_ext = 32'(emit_lane_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_take) begin
			out_lane_q <= emit_lane_ext[LANE_W-1:0];
			dist_sum_q <= dacc_rd;
			mag_sum_q  <= mag_en_q ? macc_rd : '0;
			last_q     <= emit_lane_q == LAST_LANE;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, mag_sum_q, dist_sum_q, out_lane_q};
	assign m_axis_tlast  = last_q;

endmodule

FILE: rtl/pqda_checker.sv
// port-level checker for pq_quantized_distance_accumulator, bound to the top
// uses pqda_pkg for the command codes
module pqda_checker
	import pqda_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [CMD_W-1:0]       s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tlast
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// an emit transfer is followed at once by a closed input
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_EMIT |=> !s_axis_tready)
		else $error("input open right after emit");

	// inside an emit run no input is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input open during emit run");

	// after the last lane of a run, the next result, if any, starts a run at lane zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
			!m_axis_tvalid || m_axis_tdata[LANE_W-1:0] == '0)
		else $error("result after last lane does not start a new run");

	// output is quiet out of reset
	assert property (@(posedge clk) $rose(arst_n) |-> !m_axis_tvalid)
		else $error("result valid at reset release");

endmodule

bind pq_quantized_distance_accumulator pqda_checker u_pqda_checker (.*);
